// ===== src/crd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crd_pkg;

  localparam int MAX_RESPONSES = 8;

  localparam logic [3:0] POLL_LIMIT_RESET = 4'd3;
  localparam logic [3:0] POLL_SAT = 4'd15;
  localparam logic [7:0] COUNT_SAT = 8'd255;

  // Input opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_CHAR = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // Result events
  localparam logic [2:0] EV_BODY = 3'd0;
  localparam logic [2:0] EV_SEP = 3'd1;
  localparam logic [2:0] EV_DONE = 3'd2;
  localparam logic [2:0] EV_TIMEOUT = 3'd3;
  localparam logic [2:0] EV_CMDERR = 3'd4;
  localparam logic [2:0] EV_FLUSHED = 3'd5;

  // Characters of the reply framing
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_BODY    = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_char;
    logic [3:0] response_count;
  } crd_in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] data_char;
    logic [7:0] total_length;
  } crd_out_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] header_count;
    logic [7:0] trailer_count;
    logic [3:0] empty_polls;
    logic [3:0] responses_left;
    logic [7:0] length_so_far;
  } crd_state_t;

  localparam crd_state_t ST_RESET = '{
    phase:          PH_IDLE,
    header_count:   8'd0,
    trailer_count:  8'd0,
    empty_polls:    4'd0,
    responses_left: 4'd0,
    length_so_far:  8'd0
  };

endpackage

`default_nettype wire

// ===== src/crd_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crd_step
  import crd_pkg::*;
(
  input  crd_state_t state_cur,
  input  crd_in_t    item,
  input  logic [3:0] poll_limit,
  output crd_state_t state_nxt,
  output logic       res_valid,
  output crd_out_t   res
);

  logic       is_eol;
  logic       is_mark;
  logic       is_hash;
  logic [7:0] hdr_inc;
  logic [7:0] trl_inc;
  logic [7:0] len_inc;
  logic [3:0] poll_inc;
  logic [3:0] cnt_sat;
  logic       poll_expired;
  logic       trl_done;
  logic       more_left;
  logic       busy;

  assign is_eol   = (item.rx_char == CH_CR) || (item.rx_char == CH_LF);
  assign is_mark  = is_eol || (item.rx_char == CH_DOLLAR) || (item.rx_char == CH_AT) ||
                    (item.rx_char == CH_BANG);
  assign is_hash  = (item.rx_char == CH_HASH);
  assign hdr_inc  = (state_cur.header_count == COUNT_SAT) ? COUNT_SAT
                                                           : state_cur.header_count + 8'd1;
  assign trl_inc  = (state_cur.trailer_count == COUNT_SAT) ? COUNT_SAT
                                                            : state_cur.trailer_count + 8'd1;
  assign len_inc  = (state_cur.length_so_far == COUNT_SAT) ? COUNT_SAT
                                                            : state_cur.length_so_far + 8'd1;
  assign poll_inc = (state_cur.empty_polls == POLL_SAT) ? POLL_SAT
                                                         : state_cur.empty_polls + 4'd1;
  assign cnt_sat  = (item.response_count > 4'(MAX_RESPONSES)) ? 4'(MAX_RESPONSES)
                                                               : item.response_count;
  assign poll_expired = (poll_inc >= poll_limit);
  assign trl_done     = (trl_inc >= state_cur.header_count);
  assign more_left    = (state_cur.responses_left > 4'd1);
  assign busy         = (state_cur.phase != PH_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_cur;
    unique case (item.opcode)
      OP_FLUSH: begin
        state_nxt = ST_RESET;
      end
      OP_START: begin
        state_nxt = ST_RESET;
        if (cnt_sat != 4'd0) begin
          state_nxt.responses_left = cnt_sat;
          state_nxt.phase          = PH_HEADER;
        end
      end
      OP_POLL: begin
        if (busy) begin
          state_nxt.empty_polls = poll_inc;
          if (poll_expired) begin
            state_nxt.phase          = PH_IDLE;
            state_nxt.responses_left = 4'd0;
          end
        end
      end
      OP_CHAR: begin
        unique case (state_cur.phase)
          PH_HEADER: begin
            state_nxt.empty_polls = 4'd1;
            if (is_hash) begin
              state_nxt.phase          = PH_IDLE;
              state_nxt.responses_left = 4'd0;
            end else if (is_mark) begin
              state_nxt.header_count = hdr_inc;
            end else begin
              state_nxt.phase         = PH_BODY;
              state_nxt.length_so_far = len_inc;
            end
          end
          PH_BODY: begin
            state_nxt.empty_polls = 4'd1;
            if (is_eol) begin
              state_nxt.phase         = PH_TRAILER;
              state_nxt.trailer_count = 8'd1;
            end else begin
              state_nxt.length_so_far = len_inc;
            end
          end
          PH_TRAILER: begin
            state_nxt.trailer_count = trl_inc;
            if (!trl_done) begin
              state_nxt.empty_polls = 4'd1;
            end else if (more_left) begin
              // Next response starts with fresh header, trailer and poll counts.
              state_nxt.responses_left = state_cur.responses_left - 4'd1;
              state_nxt.length_so_far  = len_inc;
              state_nxt.phase          = PH_HEADER;
              state_nxt.header_count   = 8'd0;
              state_nxt.trailer_count  = 8'd0;
              state_nxt.empty_polls    = 4'd0;
            end else begin
              state_nxt.phase          = PH_IDLE;
              state_nxt.responses_left = 4'd0;
              state_nxt.empty_polls    = 4'd0;
            end
          end
          PH_IDLE: begin
            state_nxt = state_cur;
          end
          default: begin
            state_nxt = state_cur;
          end
        endcase
      end
      default: begin
        state_nxt = state_cur;
      end
    endcase
  end

  // Result; the length reported is always the length after this item's update.
  always_comb begin
    res_valid        = 1'b0;
    res.event_res    = EV_BODY;
    res.data_char    = 8'd0;
    res.total_length = state_nxt.length_so_far;
    unique case (item.opcode)
      OP_FLUSH: begin
        res_valid     = 1'b1;
        res.event_res = EV_FLUSHED;
      end
      OP_START: begin
        if (cnt_sat == 4'd0) begin
          res_valid     = 1'b1;
          res.event_res = EV_DONE;
        end
      end
      OP_POLL: begin
        if (busy && poll_expired) begin
          res_valid     = 1'b1;
          res.event_res = EV_TIMEOUT;
        end
      end
      OP_CHAR: begin
        unique case (state_cur.phase)
          PH_HEADER: begin
            if (is_hash) begin
              res_valid     = 1'b1;
              res.event_res = EV_CMDERR;
            end else if (!is_mark) begin
              res_valid     = 1'b1;
              res.event_res = EV_BODY;
              res.data_char = item.rx_char;
            end
          end
          PH_BODY: begin
            if (!is_eol) begin
              res_valid     = 1'b1;
              res.event_res = EV_BODY;
              res.data_char = item.rx_char;
            end
          end
          PH_TRAILER: begin
            if (trl_done) begin
              res_valid = 1'b1;
              if (more_left) begin
                res.event_res = EV_SEP;
                res.data_char = CH_COMMA;
              end else begin
                res.event_res = EV_DONE;
              end
            end
          end
          PH_IDLE: begin
            res_valid = 1'b0;
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/controller_response_deframer.sv =====
// Latency: a result appears on out_valid in the cycle after its item is accepted,
// or later only while earlier results wait on out_stall.
// Throughput: one item per cycle while in_stall is low; the whole state update is one pass of logic.
// A two-entry output buffer lets one more item in while a result is stalled.
// Synchronous active-low reset: idle phase, counters zero, poll limit 3, no results.
`timescale 1ns / 1ps
`default_nettype none

module controller_response_deframer
  import crd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire crd_in_t    in_data,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      crd_out_t   out_data,
  input  wire logic       cfg_wr_en,
  input  wire logic [3:0] cfg_wr_data
);

  logic [3:0] poll_limit_r;
  crd_state_t state_r;
  crd_state_t state_nxt;
  logic       res_valid;
  crd_out_t   res;
  logic       out_valid_r;
  crd_out_t   out_data_r;
  logic       skid_valid_r;
  crd_out_t   skid_data_r;
  logic       in_accept;
  logic       out_take;
  logic       push;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign push      = in_accept && res_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  crd_step u_step (
    .state_cur  (state_r),
    .item       (in_data),
    .poll_limit (poll_limit_r),
    .state_nxt  (state_nxt),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= POLL_LIMIT_RESET;
      state_r      <= ST_RESET;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        poll_limit_r <= cfg_wr_data;
      end
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (skid_valid_r) begin
        if (out_take) begin
          skid_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (out_valid_r && !out_take) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !out_take) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/crd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crd_checker
  import crd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire crd_in_t    in_data,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire crd_out_t   out_data
);

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // After an accepted flush, out_valid is high in the following cycle.
  a_flush_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.opcode == OP_FLUSH |=> out_valid)
    else $error("flush gave no result");

  a_flushed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res == EV_FLUSHED |->
      out_data.total_length == 8'd0 && out_data.data_char == 8'd0)
    else $error("flushed result carries data");

  // A separator carries a comma and is itself counted in the length.
  a_sep_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res == EV_SEP |->
      out_data.data_char == CH_COMMA && out_data.total_length != 8'd0)
    else $error("bad separator result");

endmodule

bind controller_response_deframer crd_checker u_crd_checker (.*);

`default_nettype wire

// ===== test/tb_controller_response_deframer.sv =====
`timescale 1ns / 1ps

module tb_controller_response_deframer;
  import crd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEM_TARGET = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_PRINTS = 60;

  typedef struct packed {
    logic       is_cfg;
    logic [3:0] limit_val;
    crd_in_t    item;
    logic       typed;
    crd_out_t   res;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  crd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  crd_out_t out_data;
  logic     cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = '0;

  // A directed row may carry its result typed in; it replaces the predicted one.
  logic     typed_now = 1'b0;
  crd_out_t typed_res = '0;
  logic     calm = 1'b0;

  // Predictor state.
  phase_t     m_phase;
  logic [7:0] m_hdr;
  logic [7:0] m_trl;
  logic [7:0] m_len;
  logic [3:0] m_polls;
  logic [3:0] m_left;
  logic [3:0] m_limit;

  crd_out_t  pending_replies[$];
  plan_row_t plan[$];
  int errors = 0;
  int live_items = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int cur_limit = 3;
  int ev_hist[8];

  controller_response_deframer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] sat8(input logic [7:0] v);
    return (v == COUNT_SAT) ? v : v + 8'd1;
  endfunction

  function automatic void clear_model();
    m_phase = PH_IDLE;
    m_hdr = '0;
    m_trl = '0;
    m_len = '0;
    m_polls = '0;
    m_left = '0;
  endfunction

  function automatic void open_response();
    m_phase = PH_HEADER;
    m_hdr = '0;
    m_trl = '0;
    m_polls = '0;
  endfunction

  function automatic bit predict_reply(input crd_in_t it, output crd_out_t r);
    logic [3:0] cnt;
    logic       eol;
    r = '0;
    eol = (it.rx_char == CH_CR) || (it.rx_char == CH_LF);
    if (it.opcode == OP_FLUSH) begin
      clear_model();
      r.event_res = EV_FLUSHED;
      return 1'b1;
    end
    if (it.opcode == OP_START) begin
      clear_model();
      cnt = (it.response_count > MAX_RESPONSES) ? 4'(MAX_RESPONSES) : it.response_count;
      if (cnt == 4'd0) begin
        r.event_res = EV_DONE;
        return 1'b1;
      end
      m_left = cnt;
      open_response();
      return 1'b0;
    end
    if (m_phase == PH_IDLE) return 1'b0;

    if (it.opcode == OP_POLL) begin
      if (m_polls != POLL_SAT) m_polls = m_polls + 4'd1;
      if (m_polls < m_limit) return 1'b0;
      r.event_res = EV_TIMEOUT;
      r.total_length = m_len;
      m_phase = PH_IDLE;
      m_left = '0;
      return 1'b1;
    end

    if (m_phase == PH_TRAILER) begin
      m_trl = sat8(m_trl);
      if (m_trl < m_hdr) begin
        m_polls = 4'd1;
        return 1'b0;
      end
      if (m_left > 4'd1) begin
        m_left = m_left - 4'd1;
        m_len = sat8(m_len);
        open_response();
        r.event_res = EV_SEP;
        r.data_char = CH_COMMA;
        r.total_length = m_len;
        return 1'b1;
      end
      m_phase = PH_IDLE;
      m_left = '0;
      m_polls = '0;
      r.event_res = EV_DONE;
      r.total_length = m_len;
      return 1'b1;
    end

    m_polls = 4'd1;
    if (m_phase == PH_HEADER) begin
      if (it.rx_char == CH_HASH) begin
        r.event_res = EV_CMDERR;
        r.total_length = m_len;
        m_phase = PH_IDLE;
        m_left = '0;
        return 1'b1;
      end
      if (eol || it.rx_char == CH_DOLLAR || it.rx_char == CH_AT || it.rx_char == CH_BANG) begin
        m_hdr = sat8(m_hdr);
        return 1'b0;
      end
      // The first plain character opens the body and is passed out below.
      m_phase = PH_BODY;
    end else if (eol) begin
      m_phase = PH_TRAILER;
      m_trl = 8'd1;
      return 1'b0;
    end
    m_len = sat8(m_len);
    r.event_res = EV_BODY;
    r.data_char = it.rx_char;
    r.total_length = m_len;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Checks results, predicts accepted items and runs the watchdog.
  always @(posedge clk) begin
    crd_out_t want;
    crd_out_t got;
    bit       hit;
    if (!rst_n) begin
      clear_model();
      m_limit = POLL_LIMIT_RESET;
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (cfg_wr_en) begin
        m_limit = cfg_wr_data;
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        results_seen++;
        ev_hist[out_data.event_res]++;
        if (pending_replies.size() == 0) begin
          report_mismatch("result with nothing expected, event_res", out_data.event_res, -1);
        end else begin
          want = pending_replies.pop_front();
          if (out_data.event_res !== want.event_res)
            report_mismatch("event_res", out_data.event_res, want.event_res);
          if (out_data.data_char !== want.data_char)
            report_mismatch("data_char", out_data.data_char, want.data_char);
          if (out_data.total_length !== want.total_length)
            report_mismatch("total_length", out_data.total_length, want.total_length);
        end
      end
      if (in_valid && !in_stall) begin
        idle_cycles = 0;
        if (m_phase != PH_IDLE || in_data.opcode inside {OP_START, OP_FLUSH}) live_items++;
        hit = predict_reply(in_data, got);
        if (typed_now) pending_replies.push_back(typed_res);
        else if (hit) pending_replies.push_back(got);
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 29);
  end

  task automatic send_item(input crd_in_t it, input logic typed, input crd_out_t res);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    typed_now <= typed;
    typed_res <= res;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send(input logic [1:0] op, input logic [7:0] ch, input logic [3:0] cnt);
    crd_in_t it;
    it.opcode = op;
    it.rx_char = ch;
    it.response_count = cnt;
    send_item(it, 1'b0, '0);
  endtask

  // Lets every result drain, then waits out items that give none.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [3:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_limit = v;
  endtask

  task automatic send_noise();
    send(2'($urandom_range(3)), 8'($urandom_range(255)), 4'($urandom_range(15)));
  endtask

  // Mostly polls that stay under the limit, now and then a run that times out.
  task automatic maybe_polls();
    int n;
    if ($urandom_range(99) < 8) n = $urandom_range(4, 1);
    else if ($urandom_range(99) < 15 && cur_limit > 2) n = $urandom_range(cur_limit - 2, 1);
    else n = 0;
    repeat (n) send(OP_POLL, 8'($urandom_range(255)), 4'($urandom_range(15)));
    if ($urandom_range(199) == 0) send_noise();
  endtask

  // One well-formed transaction with random content, occasionally broken.
  task automatic reply_burst();
    int r;
    int n_resp;
    int n_hdr;
    int n_body;
    int n_trl;
    logic [3:0] cnt;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 5) cnt = 4'd0;
    else if (r < 12) cnt = 4'($urandom_range(15, 9));
    else cnt = 4'($urandom_range(8, 1));
    send(OP_START, 8'($urandom_range(255)), cnt);
    n_resp = (cnt > MAX_RESPONSES) ? MAX_RESPONSES : cnt;
    for (int i = 0; i < n_resp; i++) begin
      maybe_polls();
      n_hdr = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 0);
      for (int k = 0; k < n_hdr; k++) begin
        case ($urandom_range(4))
          0: c = CH_CR;
          1: c = CH_LF;
          2: c = CH_DOLLAR;
          3: c = CH_AT;
          default: c = CH_BANG;
        endcase
        send(OP_CHAR, c, 4'($urandom_range(15)));
        maybe_polls();
      end
      if ($urandom_range(49) == 0) begin
        send(OP_CHAR, CH_HASH, 4'($urandom_range(15)));
        return;
      end
      n_body = ($urandom_range(19) == 0) ? $urandom_range(50, 30) : $urandom_range(6, 1);
      for (int k = 0; k < n_body; k++) begin
        c = 8'($urandom_range(255));
        if (k == 0) begin
          while (c inside {CH_CR, CH_LF, CH_DOLLAR, CH_AT, CH_BANG, CH_HASH})
            c = 8'($urandom_range(255));
        end else begin
          while (c inside {CH_CR, CH_LF}) c = 8'($urandom_range(255));
        end
        send(OP_CHAR, c, 4'($urandom_range(15)));
        maybe_polls();
      end
      send(OP_CHAR, $urandom_range(1) ? CH_CR : CH_LF, 4'($urandom_range(15)));
      n_trl = (n_hdr > 2) ? n_hdr - 1 : 1;
      if ($urandom_range(19) == 0) n_trl = $urandom_range(3, 0);
      for (int k = 0; k < n_trl; k++) begin
        maybe_polls();
        send(OP_CHAR, 8'($urandom_range(255)), 4'($urandom_range(15)));
      end
    end
  endtask

  function automatic plan_row_t ask(input logic [1:0] op, input logic [7:0] ch,
                                    input logic [3:0] cnt);
    plan_row_t row;
    row = '0;
    row.item.opcode = op;
    row.item.rx_char = ch;
    row.item.response_count = cnt;
    return row;
  endfunction

  function automatic plan_row_t ask_typed(input logic [1:0] op, input logic [7:0] ch,
                                          input logic [3:0] cnt, input logic [2:0] ev);
    plan_row_t row;
    row = ask(op, ch, cnt);
    row.typed = 1'b1;
    row.res.event_res = ev;
    return row;
  endfunction

  function automatic plan_row_t set_limit(input logic [3:0] v);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.limit_val = v;
    return row;
  endfunction

  initial begin
    int bursts;
    int limit_writes;
    bursts = 0;
    limit_writes = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan.push_back(ask_typed(OP_FLUSH, 8'h00, 4'd0, EV_FLUSHED));
    // Characters and polls while idle give nothing.
    plan.push_back(ask(OP_CHAR, "A", 4'd5));
    plan.push_back(ask(OP_POLL, 8'hFF, 4'd15));
    plan.push_back(ask_typed(OP_START, 8'h00, 4'd0, EV_DONE));
    plan.push_back(ask(OP_START, 8'hFF, 4'd15));
    // A start while busy restarts the transaction.
    plan.push_back(ask(OP_START, 8'h00, 4'd1));
    plan.push_back(ask(OP_CHAR, CH_DOLLAR, 4'd0));
    plan.push_back(ask(OP_CHAR, CH_AT, 4'd0));
    plan.push_back(ask(OP_CHAR, CH_BANG, 4'd0));
    plan.push_back(ask(OP_CHAR, CH_CR, 4'd0));
    plan.push_back(ask(OP_CHAR, 8'hFF, 4'd0));
    plan.push_back(ask(OP_CHAR, 8'h00, 4'd0));
    plan.push_back(ask(OP_CHAR, CH_LF, 4'd0));
    plan.push_back(ask(OP_CHAR, "x", 4'd0));
    plan.push_back(ask(OP_POLL, 8'h00, 4'd0));
    plan.push_back(ask(OP_CHAR, "y", 4'd0));
    plan.push_back(ask(OP_CHAR, "z", 4'd0));
    plan.push_back(ask(OP_START, 8'h00, 4'd2));
    plan.push_back(ask(OP_CHAR, "a", 4'd0));
    plan.push_back(ask(OP_CHAR, CH_CR, 4'd0));
    plan.push_back(ask(OP_CHAR, "b", 4'd0));
    plan.push_back(ask(OP_POLL, 8'h00, 4'd0));
    plan.push_back(ask(OP_POLL, 8'h00, 4'd0));
    plan.push_back(ask(OP_POLL, 8'h00, 4'd0));
    plan.push_back(ask(OP_START, 8'hFF, 4'd1));
    plan.push_back(ask_typed(OP_CHAR, CH_HASH, 4'd0, EV_CMDERR));
    // A zero poll limit behaves like one: the first poll times out.
    plan.push_back(set_limit(4'd0));
    plan.push_back(ask(OP_START, 8'h00, 4'd1));
    plan.push_back(ask_typed(OP_POLL, 8'h00, 4'd0, EV_TIMEOUT));
    plan.push_back(set_limit(4'd1));
    plan.push_back(ask(OP_START, 8'h00, 4'd1));
    plan.push_back(ask(OP_CHAR, "q", 4'd0));
    plan.push_back(ask(OP_POLL, 8'h00, 4'd0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_limit(plan[i].limit_val);
      else send_item(plan[i].item, plan[i].typed, plan[i].res);
    end

    while (live_items < ITEM_TARGET) begin
      if (bursts % 20 == 0) begin
        case (limit_writes)
          0: write_limit(4'd15);
          1: write_limit(4'd2);
          2: write_limit(4'd0);
          3: write_limit(4'd3);
          4: write_limit(4'd1);
          default: write_limit(4'($urandom_range(15)));
        endcase
        limit_writes++;
      end
      calm <= (live_items >= 900 && live_items < 1200);
      if ($urandom_range(99) < 12) send_noise();
      else reply_burst();
      bursts++;
    end
    settle();

    $display("summary: %0d items acted on, %0d results, %0d poll limit writes",
             live_items, results_seen, limit_writes + 2);
    $display("summary: body %0d, separator %0d, done %0d, timeout %0d, cmd error %0d, flushed %0d",
             ev_hist[EV_BODY], ev_hist[EV_SEP], ev_hist[EV_DONE], ev_hist[EV_TIMEOUT],
             ev_hist[EV_CMDERR], ev_hist[EV_FLUSHED]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
